// File: rtl/core/tlfs_pkg.sv
// Shared types and codes for the three-level feedback scheduler.
// Used by tlfs_cell, tlfs_queue and three_level_feedback_scheduler_core.
`default_nettype none

package tlfs_pkg;

	localparam int OP_W      = 3;
	localparam int LEVEL_W   = 2;
	localparam int QUANTA_W  = 2;
	localparam int CFG_W     = 2;
	localparam int CFG_IDX_W = 2;

	// Event codes carried in the operation field.
	localparam logic [OP_W-1:0] OP_ARRIVE = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
	localparam logic [OP_W-1:0] OP_TERM   = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK  = 3'd3;
	localparam logic [OP_W-1:0] OP_WAKE   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO = 2'd1;

	// Priority levels; level 1 is the highest.
	localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_BOT  = 2'd3;

	localparam logic [QUANTA_W-1:0] QUANTA_MAX = 2'd3;

	// Per-queue operation requests for one event.
	typedef struct packed {
		logic tail_push;
		logic push_front;
		logic pop;
	} q_ctl_t;

	// Load source of one queue cell.
	typedef enum logic [2:0] {
		SEL_HOLD  = 3'd0,
		SEL_PREV  = 3'd1,
		SEL_NEXT  = 3'd2,
		SEL_BACK  = 3'd3,
		SEL_FRONT = 3'd4
	} cell_sel_t;

endpackage

`default_nettype wire

// File: rtl/core/tlfs_cell.sv
// One storage cell of a scheduler queue: holds one entry and loads from its
// neighbors or from the push ports. Depends on tlfs_pkg.
`default_nettype none

module tlfs_cell #(
	parameter int WIDTH = 8
) (
	input  wire                   clk,
	input  tlfs_pkg::cell_sel_t   sel,
	input  wire [WIDTH-1:0]       prev,
	input  wire [WIDTH-1:0]       next,
	input  wire [WIDTH-1:0]       back_data,
	input  wire [WIDTH-1:0]       front_data,
	output logic [WIDTH-1:0]      data
);
	import tlfs_pkg::*;

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			SEL_HOLD:  data_q <= data_q;
			SEL_PREV:  data_q <= prev;
			SEL_NEXT:  data_q <= next;
			SEL_BACK:  data_q <= back_data;
			SEL_FRONT: data_q <= front_data;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: rtl/core/tlfs_queue.sv
// Scheduler queue built as a row of tlfs_cell with the head in cell 0.
// Supports tail push, front push and pop in the same cycle. Depends on tlfs_pkg.
`default_nettype none

module tlfs_queue #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  tlfs_pkg::q_ctl_t             ctl,
	input  wire [WIDTH-1:0]              back_data,
	input  wire [WIDTH-1:0]              front_data,
	output logic [WIDTH-1:0]             head,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         full
);
	import tlfs_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] back_idx;
	logic             back_acc;
	logic             back_wr;
	logic             shift_right;
	logic             shift_left;
	logic [WIDTH-1:0] cell_data [DEPTH];

	assign full        = (count_q == CNT_W'(DEPTH));
	assign back_acc    = ctl.tail_push && !full;
	assign shift_right = ctl.push_front && !ctl.pop;
	assign shift_left  = ctl.pop && !ctl.push_front;
	assign back_idx    = count_q + CNT_W'(ctl.push_front) - CNT_W'(ctl.pop);
	// A tail push into an empty queue that is popped at once never lands in a cell.
	assign back_wr     = back_acc && !(ctl.pop && count_q == '0);
	assign head        = (count_q == '0) ? back_data : cell_data[0];
	assign count       = count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_sel_t        sel;
		logic [WIDTH-1:0] prev;
		logic [WIDTH-1:0] next;

		assign prev = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i-1];
		assign next = (i == DEPTH-1) ? cell_data[i] : cell_data[(i == DEPTH-1) ? i : i+1];

		always_comb begin
			priority if (i == 0 && ctl.push_front) begin
				sel = SEL_FRONT;
			end else if (back_wr && back_idx == CNT_W'(i)) begin
				sel = SEL_BACK;
			end else if (shift_right) begin
				sel = SEL_PREV;
			end else if (shift_left) begin
				sel = SEL_NEXT;
			end else begin
				sel = SEL_HOLD;
			end
		end

		tlfs_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk       (clk),
			.sel       (sel),
			.prev      (prev),
			.next      (next),
			.back_data (back_data),
			.front_data(front_data),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CNT_W'(back_acc) + CNT_W'(ctl.push_front) - CNT_W'(ctl.pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (count_q != '0) || ctl.tail_push)
		else $error("pop from an empty queue");

	a_front_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push_front |-> (count_q + CNT_W'(back_acc)) != CNT_W'(DEPTH))
		else $error("front push into a full queue");

endmodule

`default_nettype wire

// File: rtl/core/three_level_feedback_scheduler_core.sv
// Channel  Dir  Fields (lowest bit first)
// s_       in   operation[2:0], wake_pid, wake_level
// m_       out  running_pid, running_level, released_valid, released_pid,
//                released_level, overflow
// cfg_     in   index 0 quantum_level_one, index 1 quantum_level_two
//
// For each event the queues, the processor register and the output register
// all load at the accepting edge, and the result is offered in the cycle
// right after it. The path from the queue counts through the level search
// to the cell loads is combinational. A new item is taken while the result
// is being taken. Reset clears the processor register, the arrival counter
// and all queue counts at once; no clearing pass is needed. A stalled result
// holds the input side off.
// Depends on tlfs_pkg, tlfs_queue and tlfs_cell.
`default_nettype none

module three_level_feedback_scheduler_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PID_BITS    = 8
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     s_tvalid,
	output logic                                    s_tready,
	// operation, wake_pid, wake_level
	input  wire [((PID_BITS+12)/8)*8-1:0]           s_tdata,
	output logic                                    m_tvalid,
	input  wire                                     m_tready,
	// running_pid, running_level, released_valid, released_pid, released_level, overflow
	output logic [((2*PID_BITS+13)/8)*8-1:0]        m_tdata,
	input  wire                                     cfg_we,
	input  wire [tlfs_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire [tlfs_pkg::CFG_W-1:0]               cfg_data
);
	import tlfs_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
	localparam int OUT_W = ((2*PID_BITS+13)/8)*8;
	localparam int MID_W = PID_BITS + QUANTA_W;

	logic                  fire;
	logic [OP_W-1:0]       op;
	logic [PID_BITS-1:0]   w_pid;
	logic [LEVEL_W-1:0]    w_lvl;

	logic [QUANTA_W-1:0]   ql1_q, ql2_q;
	logic [PID_BITS-1:0]   run_pid_q;
	logic [LEVEL_W-1:0]    run_level_q;
	logic [QUANTA_W-1:0]   run_quanta_q;
	logic [PID_BITS-1:0]   pid_ctr_q;

	logic                  out_valid_q;
	logic [PID_BITS-1:0]   out_pid_q;
	logic [LEVEL_W-1:0]    out_level_q;
	logic                  rel_valid_q;
	logic [PID_BITS-1:0]   rel_pid_q;
	logic [LEVEL_W-1:0]    rel_level_q;
	logic                  ovf_q;

	// Queue side.
	q_ctl_t                q_ctl [3];
	logic [CNT_W-1:0]      q_count [3];
	logic                  q_full [3];
	logic [PID_BITS-1:0]   head_pid [3];
	logic [QUANTA_W-1:0]   head_quanta [3];
	logic [MID_W-1:0]      mid_head;

	// Event decode results.
	logic                  pb_en;
	logic [1:0]            pb_idx;
	logic [PID_BITS-1:0]   pb_pid;
	logic                  pf_en;
	logic [1:0]            pf_idx;
	logic [PID_BITS-1:0]   pf_pid;
	logic [QUANTA_W-1:0]   pf_quanta;
	logic                  pop_en;
	logic [1:0]            pop_idx;
	logic                  repick_en;
	logic [PID_BITS-1:0]   run_pid_d;
	logic [LEVEL_W-1:0]    run_level_d;
	logic [QUANTA_W-1:0]   run_quanta_d;
	logic [PID_BITS-1:0]   pid_ctr_d;
	logic                  rel_valid_d;
	logic [PID_BITS-1:0]   rel_pid_d;
	logic [LEVEL_W-1:0]    rel_level_d;
	logic                  ovf_d;
	logic [QUANTA_W-1:0]   used;
	logic [QUANTA_W-1:0]   limit;
	logic [CNT_W-1:0]      count1 [3];
	logic [CNT_W-1:0]      own_count;
	logic [LEVEL_W-1:0]    hi;

	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;
	assign op       = s_tdata[OP_W-1:0];
	assign w_pid    = s_tdata[OP_W +: PID_BITS];
	assign w_lvl    = s_tdata[OP_W+PID_BITS +: LEVEL_W];

	always_comb begin
		pb_en        = 1'b0;
		pb_idx       = 2'd0;
		pb_pid       = '0;
		pf_en        = 1'b0;
		pf_idx       = 2'd0;
		pf_pid       = '0;
		pf_quanta    = '0;
		pop_en       = 1'b0;
		pop_idx      = 2'd0;
		repick_en    = 1'b1;
		run_pid_d    = run_pid_q;
		run_level_d  = run_level_q;
		run_quanta_d = run_quanta_q;
		pid_ctr_d    = pid_ctr_q;
		rel_valid_d  = 1'b0;
		rel_pid_d    = '0;
		rel_level_d  = LVL_NONE;
		used         = (run_quanta_q == QUANTA_MAX) ? QUANTA_MAX : run_quanta_q + 2'd1;
		limit        = (run_level_q == LVL_TOP) ? ql1_q : ql2_q;

		unique case (op)
			OP_ARRIVE: begin
				pid_ctr_d = pid_ctr_q + 1'b1;
				pb_en     = 1'b1;
				pb_idx    = 2'd0;
				pb_pid    = pid_ctr_d;
			end
			OP_TICK: begin
				if (run_level_q == LVL_TOP || run_level_q == LVL_MID) begin
					if (used >= limit) begin
						// Demote to the tail of the next lower queue.
						pb_en        = 1'b1;
						pb_idx       = run_level_q;
						pb_pid       = run_pid_q;
						run_pid_d    = '0;
						run_level_d  = LVL_NONE;
						run_quanta_d = '0;
					end else begin
						run_quanta_d = used;
					end
				end
			end
			OP_TERM: begin
				run_pid_d    = '0;
				run_level_d  = LVL_NONE;
				run_quanta_d = '0;
			end
			OP_BLOCK: begin
				if (run_level_q != LVL_NONE) begin
					rel_valid_d = 1'b1;
					rel_pid_d   = run_pid_q;
					rel_level_d = run_level_q;
				end
				run_pid_d    = '0;
				run_level_d  = LVL_NONE;
				run_quanta_d = '0;
			end
			OP_WAKE: begin
				pb_en  = 1'b1;
				pb_idx = (w_lvl == LVL_TOP) ? 2'd0 : (w_lvl == LVL_MID) ? 2'd1 : 2'd2;
				pb_pid = w_pid;
			end
			default: begin
				repick_en = 1'b0;
			end
		endcase

		ovf_d = 1'b0;
		for (int l = 0; l < 3; l++) begin
			if (pb_en && pb_idx == 2'(l) && !q_full[l]) begin
				count1[l] = q_count[l] + 1'b1;
			end else begin
				count1[l] = q_count[l];
			end
			if (pb_en && pb_idx == 2'(l) && q_full[l]) begin
				ovf_d = 1'b1;
			end
		end

		priority if (count1[0] != '0) begin
			hi = LVL_TOP;
		end else if (count1[1] != '0) begin
			hi = LVL_MID;
		end else if (count1[2] != '0) begin
			hi = LVL_BOT;
		end else begin
			hi = LVL_NONE;
		end

		unique case (run_level_d)
			LVL_TOP: own_count = count1[0];
			LVL_MID: own_count = count1[1];
			LVL_BOT: own_count = count1[2];
			default: own_count = '0;
		endcase

		if (repick_en && hi != LVL_NONE) begin
			if (run_level_d == LVL_NONE) begin
				pop_en = 1'b1;
			end else if (hi < run_level_d && own_count != CNT_W'(QUEUE_DEPTH)) begin
				// Preempted process returns to the front of its own queue.
				pf_en     = 1'b1;
				pf_idx    = run_level_d - 2'd1;
				pf_pid    = run_pid_d;
				pf_quanta = run_quanta_d;
				pop_en    = 1'b1;
			end
		end

		if (pop_en) begin
			pop_idx      = hi - 2'd1;
			run_pid_d    = head_pid[pop_idx];
			run_quanta_d = head_quanta[pop_idx];
			run_level_d  = hi;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_ctl
		assign q_ctl[l].tail_push  = fire && pb_en && pb_idx == 2'(l);
		assign q_ctl[l].push_front = fire && pf_en && pf_idx == 2'(l);
		assign q_ctl[l].pop        = fire && pop_en && pop_idx == 2'(l);
	end

	// Only middle-level entries can carry used quanta; the other two levels
	// always hold zero there.
	tlfs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(PID_BITS)
	) u_top_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl[0]),
		.back_data (pb_pid),
		.front_data(pf_pid),
		.head      (head_pid[0]),
		.count     (q_count[0]),
		.full      (q_full[0])
	);

	tlfs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(MID_W)
	) u_middle_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl[1]),
		.back_data ({{QUANTA_W{1'b0}}, pb_pid}),
		.front_data({pf_quanta, pf_pid}),
		.head      (mid_head),
		.count     (q_count[1]),
		.full      (q_full[1])
	);

	tlfs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(PID_BITS)
	) u_bottom_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl[2]),
		.back_data (pb_pid),
		.front_data(pf_pid),
		.head      (head_pid[2]),
		.count     (q_count[2]),
		.full      (q_full[2])
	);

	assign head_pid[1]    = mid_head[PID_BITS-1:0];
	assign head_quanta[0] = '0;
	assign head_quanta[1] = mid_head[MID_W-1:PID_BITS];
	assign head_quanta[2] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ql1_q        <= 2'd1;
			ql2_q        <= 2'd2;
			run_pid_q    <= '0;
			run_level_q  <= LVL_NONE;
			run_quanta_q <= '0;
			pid_ctr_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_QUANTUM_ONE) begin
					ql1_q <= cfg_data;
				end else if (cfg_index == CFG_QUANTUM_TWO) begin
					ql2_q <= cfg_data;
				end
			end
			if (fire) begin
				run_pid_q    <= run_pid_d;
				run_level_q  <= run_level_d;
				run_quanta_q <= run_quanta_d;
				pid_ctr_q    <= pid_ctr_d;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_pid_q   <= (run_level_d != LVL_NONE) ? run_pid_d : '0;
			out_level_q <= run_level_d;
			rel_valid_q <= rel_valid_d;
			rel_pid_q   <= rel_pid_d;
			rel_level_q <= rel_level_d;
			ovf_q       <= ovf_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({ovf_q, rel_level_q, rel_pid_q, rel_valid_q, out_level_q, out_pid_q});

	a_idle_means_empty: assert property (@(posedge clk) disable iff (!arst_n)
		run_level_q == LVL_NONE |->
			q_count[0] == '0 && q_count[1] == '0 && q_count[2] == '0)
		else $error("processor idle while a queue holds work");

	a_release_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && rel_valid_q |-> rel_level_q != LVL_NONE)
		else $error("released process without a level");

	a_arrive_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_ARRIVE |=> !rel_valid_q)
		else $error("arrival reported a released process");

	a_bottom_no_quanta: assert property (@(posedge clk) disable iff (!arst_n)
		run_level_q == LVL_BOT |-> run_quanta_q == '0)
		else $error("bottom-level process carries used quanta");

endmodule

`default_nettype wire

// File: dv/tlfs_sched_checker.sv
// Scoreboard for the three-level feedback scheduler: watches the item, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on tlfs_pkg for the event codes, levels and register indexes.
module tlfs_sched_checker #(
	parameter int QUEUE_DEPTH = 16,
	parameter int S_W         = 16,
	parameter int M_W         = 24
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	input  wire                              s_tready,
	input  wire [S_W-1:0]                    s_tdata,
	input  wire                              m_tvalid,
	input  wire                              m_tready,
	input  wire [M_W-1:0]                    m_tdata,
	input  wire                              cfg_we,
	input  wire [tlfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [tlfs_pkg::CFG_W-1:0]        cfg_data,
	output int                               mismatches,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlfs_pkg::*;

	// Declared from the top bit down, so running_pid lands in the lowest bits.
	typedef struct packed {
		logic         overflow;
		logic [1:0]   rel_level;
		logic [7:0]   rel_pid;
		logic         rel_valid;
		logic [1:0]   run_level;
		logic [7:0]   run_pid;
	} sched_out_t;

	typedef struct packed {
		logic [7:0]   pid;
		logic [1:0]   quanta;
	} waiter_t;

	waiter_t      wait_q [3][QUEUE_DEPTH];
	int           q_head [3];
	int           q_len [3];
	logic [7:0]   cpu_pid;
	logic [1:0]   cpu_level;
	logic [1:0]   cpu_quanta;
	logic [7:0]   arrival_count;
	logic [1:0]   q1_limit;
	logic [1:0]   q2_limit;
	logic         dropped;
	sched_out_t   awaited_outcomes [$];
	int           err_cnt;

	assign mismatches = err_cnt;

	initial begin
		for (int l = 0; l < 3; l++) begin
			q_head[l] = 0;
			q_len[l] = 0;
		end
		cpu_pid = '0;
		cpu_level = LVL_NONE;
		cpu_quanta = '0;
		arrival_count = '0;
		q1_limit = 2'd1;
		q2_limit = 2'd2;
		dropped = 1'b0;
		err_cnt = 0;
	end

	function automatic void enqueue_tail(int ix, logic [7:0] pid, logic [1:0] quanta);
		int slot;
		if (q_len[ix] >= QUEUE_DEPTH) begin
			dropped = 1'b1;
			return;
		end
		slot = (q_head[ix] + q_len[ix]) % QUEUE_DEPTH;
		wait_q[ix][slot].pid = pid;
		wait_q[ix][slot].quanta = quanta;
		q_len[ix]++;
	endfunction

	function automatic void enqueue_front(int ix, logic [7:0] pid, logic [1:0] quanta);
		q_head[ix] = (q_head[ix] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
		wait_q[ix][q_head[ix]].pid = pid;
		wait_q[ix][q_head[ix]].quanta = quanta;
		q_len[ix]++;
	endfunction

	function automatic void dispatch_head(int ix);
		cpu_pid = wait_q[ix][q_head[ix]].pid;
		cpu_quanta = wait_q[ix][q_head[ix]].quanta;
		cpu_level = 2'(ix + 1);
		q_head[ix] = (q_head[ix] + 1) % QUEUE_DEPTH;
		q_len[ix]--;
	endfunction

	function automatic void idle_cpu();
		cpu_pid = '0;
		cpu_level = LVL_NONE;
		cpu_quanta = '0;
	endfunction

	// A running process is displaced only by a strictly higher queue, and only
	// when its own queue has room to take it back at the front.
	function automatic void reschedule();
		int top_ix;
		top_ix = -1;
		for (int l = 2; l >= 0; l--)
			if (q_len[l] > 0)
				top_ix = l;
		if (top_ix < 0)
			return;
		if (cpu_level == LVL_NONE) begin
			dispatch_head(top_ix);
		end else if (top_ix + 1 < int'(cpu_level)) begin
			if (q_len[int'(cpu_level) - 1] < QUEUE_DEPTH) begin
				enqueue_front(int'(cpu_level) - 1, cpu_pid, cpu_quanta);
				dispatch_head(top_ix);
			end
		end
	endfunction

	function automatic void charge_quantum();
		int used;
		int lim;
		if (cpu_level != LVL_TOP && cpu_level != LVL_MID)
			return;
		used = (cpu_quanta < QUANTA_MAX) ? int'(cpu_quanta) + 1 : int'(QUANTA_MAX);
		lim = (cpu_level == LVL_TOP) ? int'(q1_limit) : int'(q2_limit);
		if (used >= lim) begin
			// The queue below has index equal to the current level.
			enqueue_tail(int'(cpu_level), cpu_pid, '0);
			idle_cpu();
		end else begin
			cpu_quanta = 2'(used);
		end
	endfunction

	function automatic sched_out_t schedule_event(logic [2:0] op, logic [7:0] wpid,
		logic [1:0] wlvl);
		sched_out_t r;
		r = '0;
		dropped = 1'b0;
		case (op)
			OP_ARRIVE: begin
				arrival_count = arrival_count + 8'd1;
				enqueue_tail(0, arrival_count, '0);
				reschedule();
			end
			OP_TICK: begin
				charge_quantum();
				reschedule();
			end
			OP_TERM: begin
				idle_cpu();
				reschedule();
			end
			OP_BLOCK: begin
				if (cpu_level != LVL_NONE) begin
					r.rel_valid = 1'b1;
					r.rel_pid = cpu_pid;
					r.rel_level = cpu_level;
				end
				idle_cpu();
				reschedule();
			end
			OP_WAKE: begin
				enqueue_tail((wlvl == LVL_TOP) ? 0 : (wlvl == LVL_MID) ? 1 : 2, wpid, '0);
				reschedule();
			end
			default: begin
			end
		endcase
		r.run_pid = (cpu_level != LVL_NONE) ? cpu_pid : '0;
		r.run_level = cpu_level;
		r.overflow = dropped;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		sched_out_t want;
		sched_out_t got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_QUANTUM_ONE: q1_limit = cfg_data;
					CFG_QUANTUM_TWO: q2_limit = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				awaited_outcomes.insert(awaited_outcomes.size(),
					schedule_event(s_tdata[2:0], s_tdata[10:3], s_tdata[12:11]));
			if (m_tvalid && m_tready) begin
				got = sched_out_t'(m_tdata[$bits(sched_out_t)-1:0]);
				if (awaited_outcomes.size() == 0) begin
					$error("result item with no expectation: data %h", m_tdata);
					err_cnt++;
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("running_pid", want.run_pid, got.run_pid);
					check_field("running_level", want.run_level, got.run_level);
					check_field("released_valid", want.rel_valid, got.rel_valid);
					check_field("released_pid", want.rel_pid, got.rel_pid);
					check_field("released_level", want.rel_level, got.rel_level);
					check_field("overflow", want.overflow, got.overflow);
				end
			end
			pending <= awaited_outcomes.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Top of the scheduler testbench: clock, reset, event stimulus, result back-pressure
// and the verdict. Instantiates three_level_feedback_scheduler_core and the
// tlfs_sched_checker scoreboard; depends on tlfs_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tlfs_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 8;
	localparam int S_W         = ((PID_BITS + 12) / 8) * 8;
	localparam int M_W         = ((2 * PID_BITS + 13) / 8) * 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 150;

	// Operation codes that the block ignores.
	localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;

	typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_W-1:0]       s_tdata;   // operation, wake_pid, wake_level
	logic                 m_tvalid;
	logic                 m_tready;
	// running_pid, running_level, released_valid, released_pid, released_level, overflow
	logic [M_W-1:0]       m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   pending;
	bit                   calm;
	bit                   hold_req;
	int                   quiet;

	three_level_feedback_scheduler_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PID_BITS(PID_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tlfs_sched_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.S_W(S_W),
		.M_W(M_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: short random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_event(input logic [2:0] op, input logic [7:0] pid,
		input logic [1:0] lvl);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, lvl, pid, op};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stops offering items and waits until every result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_quanta(input logic [1:0] q1, input logic [1:0] q2);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_QUANTUM_ONE;
		cfg_data <= q1;
		@(negedge clk);
		cfg_index <= CFG_QUANTUM_TWO;
		cfg_data <= q2;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [2:0] draw_op(mix_t mix);
		int r;
		int arr;
		int tck;
		int trm;
		int blk;
		int wak;
		case (mix)
			MIX_FILL: begin
				arr = 50; tck = 15; trm = 3; blk = 5; wak = 24;
			end
			MIX_DRAIN: begin
				arr = 15; tck = 40; trm = 20; blk = 15; wak = 7;
			end
			default: begin
				arr = 28; tck = 30; trm = 10; blk = 12; wak = 16;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < arr)
			return OP_ARRIVE;
		r -= arr;
		if (r < tck)
			return OP_TICK;
		r -= tck;
		if (r < trm)
			return OP_TERM;
		r -= trm;
		if (r < blk)
			return OP_BLOCK;
		r -= blk;
		if (r < wak)
			return OP_WAKE;
		return 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
	endfunction

	task automatic run_phase(input logic [1:0] q1, input logic [1:0] q2, input mix_t mix,
		input int count, input bit with_hold);
		drain();
		set_quanta(q1, q2);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 60)
				hold_req = 1'b1;
			send_event(draw_op(mix), 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		quiet = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed events under the reset quanta: idle cases, ignored codes,
		// demotion, preemption, release on block and wakeups at every level.
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_TERM, 8'hff, LVL_BOT);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);
		send_event(OP_UNUSED_A, 8'hff, LVL_BOT);
		send_event(OP_UNUSED_B, 8'h55, LVL_TOP);
		send_event(OP_UNUSED_C, 8'haa, LVL_MID);
		send_event(OP_ARRIVE, 8'h00, LVL_NONE);
		send_event(OP_UNUSED_C, 8'hff, LVL_TOP);
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_ARRIVE, 8'hff, LVL_BOT);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);
		send_event(OP_WAKE, 8'hff, LVL_TOP);
		send_event(OP_WAKE, 8'h00, LVL_NONE);
		send_event(OP_WAKE, 8'haa, LVL_BOT);
		send_event(OP_WAKE, 8'h55, LVL_MID);
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_TERM, 8'h00, LVL_NONE);
		send_event(OP_TERM, 8'h00, LVL_NONE);
		send_event(OP_TICK, 8'h00, LVL_NONE);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);
		send_event(OP_BLOCK, 8'h00, LVL_NONE);

		run_phase(2'd3, 2'd3, MIX_EVEN, 330, 1'b0);
		run_phase(2'd1, 2'd1, MIX_FILL, 330, 1'b1);
		run_phase(2'd2, 2'd3, MIX_DRAIN, 330, 1'b0);
		run_phase(2'd0, 2'd0, MIX_EVEN, 330, 1'b0);
		run_phase(2'd3, 2'd1, MIX_FILL, 330, 1'b0);
		drain();
		calm = 1'b1;
		run_phase(2'd1, 2'd2, MIX_EVEN, 330, 1'b0);
		drain();
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
